// File: rtl/core/hpq_pkg.sv
// Shared types and codes for the binary max-heap priority queue.
// No dependencies; imported by the controller, the top level and the checker.
package hpq_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic [1:0]         status;
    logic [7:0]         count;
  } out_word_t;

endpackage

// File: rtl/core/hpq_store.sv
// Heap storage: one synchronous RAM, one write port and two registered read ports.
// No package dependency.
module hpq_store #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic signed [31:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic signed [31:0]         rdata_a,
  output logic signed [31:0]         rdata_b
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/hpq_ctrl.sv
// Heap sequencer: decodes operations, walks sift-up and sift-down one level per
// cycle against hpq_store, and holds the result word. Uses hpq_pkg.
module hpq_ctrl import hpq_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    func,
  input  logic signed [31:0]            value,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output out_word_t                     rsp_word,
  output logic                          we,
  output logic [$clog2(CAPACITY)-1:0]   waddr,
  output logic signed [31:0]            wdata,
  output logic [$clog2(CAPACITY)-1:0]   raddr_a,
  output logic [$clog2(CAPACITY)-1:0]   raddr_b,
  input  logic signed [31:0]            rdata_a,
  input  logic signed [31:0]            rdata_b
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ROOT, S_UP, S_DOWN, S_PLACE, S_FINISH
  } state_t;

  state_t             state, state_next;
  logic               op_extract, op_extract_next;
  logic [AW-1:0]      hole, hole_next;
  logic signed [31:0] carry, carry_next;
  logic [CW-1:0]      cnt, cnt_next;
  out_word_t          res, res_next;

  logic [AW+1:0]      left_idx, right_idx, best_idx, best_left, best_right;
  logic               left_ok, right_ok;
  logic signed [31:0] big;
  logic               slot_free;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] h);
    return (h - AW'(1)) >> 1;
  endfunction

  assign req_stall = (state != S_IDLE);
  assign slot_free = !rsp_valid || !rsp_stall;

  // Child selection for sift-down; ties keep the parent, then the left child.
  always_comb begin
    left_idx  = {1'b0, hole, 1'b1};
    right_idx = left_idx + (AW+2)'(1);
    left_ok   = left_idx < (AW+2)'(cnt);
    right_ok  = right_idx < (AW+2)'(cnt);
    big       = carry;
    best_idx  = (AW+2)'(hole);
    if (left_ok && rdata_a > big) begin
      big      = rdata_a;
      best_idx = left_idx;
    end
    if (right_ok && rdata_b > big) begin
      big      = rdata_b;
      best_idx = right_idx;
    end
    best_left  = {best_idx[AW:0], 1'b1};
    best_right = best_left + (AW+2)'(1);
  end

  always_comb begin
    state_next      = state;
    op_extract_next = op_extract;
    hole_next       = hole;
    carry_next      = carry;
    cnt_next        = cnt;
    res_next        = res;
    we              = 1'b0;
    waddr           = hole;
    wdata           = carry;
    raddr_a         = '0;
    raddr_b         = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_extract_next = (func == OP_EXTRACT);
          case (func)
            OP_INSERT: begin
              if (cnt == CW'(CAPACITY)) begin
                res_next   = '{max_value: '0, status: ST_FULL, count: 8'(cnt)};
                state_next = S_FINISH;
              end else begin
                cnt_next   = cnt + CW'(1);
                carry_next = value;
                hole_next  = cnt[AW-1:0];
                res_next   = '{max_value: '0, status: ST_OK, count: 8'(cnt + CW'(1))};
                if (cnt == '0) begin
                  we         = 1'b1;
                  waddr      = '0;
                  wdata      = value;
                  state_next = S_FINISH;
                end else begin
                  raddr_a    = parent_of(cnt[AW-1:0]);
                  state_next = S_UP;
                end
              end
            end
            OP_EXTRACT, OP_PEEK: begin
              if (cnt == '0) begin
                res_next   = '{max_value: EMPTY_VALUE, status: ST_EMPTY, count: 8'(cnt)};
                state_next = S_FINISH;
              end else begin
                raddr_a    = '0;
                raddr_b    = AW'(cnt - CW'(1));
                state_next = S_ROOT;
              end
            end
            default: begin
              res_next   = '{max_value: '0, status: ST_OK, count: 8'(cnt)};
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_ROOT: begin
        if (!op_extract) begin
          res_next   = '{max_value: rdata_a, status: ST_OK, count: 8'(cnt)};
          state_next = S_FINISH;
        end else begin
          // move the last element into the root hole and sift it down
          cnt_next   = cnt - CW'(1);
          carry_next = rdata_b;
          hole_next  = '0;
          res_next   = '{max_value: rdata_a, status: ST_OK, count: 8'(cnt - CW'(1))};
          if (cnt == CW'(1)) begin
            state_next = S_FINISH;
          end else begin
            raddr_a    = AW'(1);
            raddr_b    = AW'(2);
            state_next = S_DOWN;
          end
        end
      end
      S_UP: begin
        we = 1'b1;
        if (carry > rdata_a) begin
          wdata     = rdata_a;
          hole_next = parent_of(hole);
          if (parent_of(hole) == '0) begin
            state_next = S_PLACE;
          end else begin
            raddr_a = parent_of(parent_of(hole));
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (best_idx != (AW+2)'(hole)) begin
          wdata     = big;
          hole_next = best_idx[AW-1:0];
          raddr_a   = best_left[AW-1:0];
          raddr_b   = best_right[AW-1:0];
        end else begin
          state_next = S_FINISH;
        end
      end
      S_PLACE: begin
        we         = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_FINISH && slot_free) begin
        rsp_valid <= 1'b1;
        rsp_word  <= res;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    op_extract <= op_extract_next;
    hole       <= hole_next;
    carry      <= carry_next;
    res        <= res_next;
  end

endmodule

// File: rtl/core/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit values, CAPACITY entries deep.
// Each request word is an insert, extract-maximum or peek-maximum; each one yields
// exactly one response word carrying a value (the root on peek and extract), a
// status and the element count (low 8 bits). One request is worked at a time:
// req_stall is high from acceptance until the response is loaded into the output
// register, which may still be waiting on rsp_stall while the next request is taken;
// a response still stalled holds the next one in its final cycle. Each heap level
// is one step, waiting on the registered read of the heap RAM: peek reads the root,
// insert into an empty heap writes the root directly, any other insert steps up once
// per level the value rises, and extract moves the last element into the root and,
// unless that empties the heap, steps down once per level the element sinks.
// Full inserts, empty reads and the unused operation code go straight to the response.
// Depends on hpq_pkg, hpq_ctrl and hpq_store.
module max_heap_priority_queue import hpq_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] max_value,
  output logic [1:0]         status,
  output logic [7:0]         count
);

  localparam int AW = $clog2(CAPACITY);

  out_word_t          rsp_word;
  logic               we;
  logic [AW-1:0]      waddr, raddr_a, raddr_b;
  logic signed [31:0] wdata, rdata_a, rdata_b;

  // Sequencer: decode, sift walks and the response register
  hpq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .value     (value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b)
  );

  // Heap array; port B serves the last element on extract and the right child
  hpq_store #(.DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign max_value = rsp_word.max_value;
  assign status    = rsp_word.status;
  assign count     = rsp_word.count;

endmodule

// File: rtl/core/hpq_checker.sv
// Port-level checks for the max-heap priority queue, bound to the top level.
// Uses hpq_pkg.
module hpq_checker import hpq_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic signed [31:0] max_value,
  input logic [1:0]         status,
  input logic [7:0]         count
);

  // hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(max_value) && $stable(status)
      && $stable(count))
    else $error("response word changed while stalled");

  // an accepted request blocks the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous still in progress");

  // a response only follows work on a request
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response appeared without an accepted request");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> max_value == EMPTY_VALUE && count == '0)
    else $error("empty status with bad value or count");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> max_value == '0 && count == 8'(CAPACITY))
    else $error("full status with bad value or count");

endmodule

bind max_heap_priority_queue hpq_checker #(.CAPACITY(CAPACITY)) u_hpq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .max_value (max_value),
  .status    (status),
  .count     (count)
);
